### design/pbp_pkg.sv
// package for the packet block placement unit
// holds field widths, reset constants, packet and destination codes and the result type
// no dependencies
package pbp_pkg;

	// field widths fixed by the packet format
	localparam int KIND_W   = 2;
	localparam int OFFS_W   = 48;
	localparam int BYTES_W  = 16;
	localparam int DEST_W   = 3;
	localparam int SIZE_W   = 32;
	localparam int TOTAL_W  = 64;

	// default stream offset width and block size after reset
	localparam int OFFSET_BITS_DEF = 48;
	localparam logic [SIZE_W-1:0] BLOCK_SIZE_RESET = 32'd1048576;

	// packet kinds from the decoder
	typedef enum logic [KIND_W-1:0] {
		KIND_DATA   = 2'd0,
		KIND_IGNORE = 2'd1,
		KIND_STOP   = 2'd2,
		KIND_SPARE  = 2'd3
	} kind_t;

	// where an item went
	typedef enum logic [DEST_W-1:0] {
		DEST_CURRENT = 3'd0,
		DEST_NEXT    = 3'd1,
		DEST_LATE    = 3'd2,
		DEST_IGNORED = 3'd3,
		DEST_BEYOND  = 3'd4
	} dest_t;

	// one result item
	typedef struct packed {
		dest_t               destination;
		logic [SIZE_W-1:0]   write_address;
		logic                consumed;
		logic                block_closed;
		logic [SIZE_W-1:0]   bytes_missing;
		logic                stop_request;
		logic [TOTAL_W-1:0]  received_total;
		logic [TOTAL_W-1:0]  dropped_total;
	} result_t;

endpackage

### design/pbp_if.sv
// valid/ready channel interfaces for packets in and placement results out
// depends on pbp_pkg for the field widths
interface pbp_pkt_if;
	logic                              valid;
	logic                              ready;
	logic [pbp_pkg::KIND_W-1:0]        packet_kind;
	logic [pbp_pkg::OFFS_W-1:0]        packet_offset;
	logic [pbp_pkg::BYTES_W-1:0]       packet_bytes;

	modport source (output valid, packet_kind, packet_offset, packet_bytes, input ready);
	modport sink   (input valid, packet_kind, packet_offset, packet_bytes, output ready);
endinterface

interface pbp_res_if;
	logic                              valid;
	logic                              ready;
	logic [pbp_pkg::DEST_W-1:0]        destination;
	logic [pbp_pkg::SIZE_W-1:0]        write_address;
	logic                              consumed;
	logic                              block_closed;
	logic [pbp_pkg::SIZE_W-1:0]        bytes_missing;
	logic                              stop_request;
	logic [pbp_pkg::TOTAL_W-1:0]       received_total;
	logic [pbp_pkg::TOTAL_W-1:0]       dropped_total;

	modport source (output valid, destination, write_address, consumed, block_closed,
		bytes_missing, stop_request, received_total, dropped_total, input ready);
	modport sink   (input valid, destination, write_address, consumed, block_closed,
		bytes_missing, stop_request, received_total, dropped_total, output ready);
endinterface

### design/pbp_core.sv
// placement logic for one packet: window compare, fill update, block close and totals
// depends on pbp_pkg
module pbp_core #(
	parameter int OFFSET_BITS = pbp_pkg::OFFSET_BITS_DEF
) (
	input  logic [pbp_pkg::KIND_W-1:0]   kind,
	input  logic [OFFSET_BITS-1:0]       offset,
	input  logic [pbp_pkg::BYTES_W-1:0]  bytes,
	input  logic [pbp_pkg::SIZE_W-1:0]   block_size,
	input  logic [OFFSET_BITS-1:0]       window_start,
	input  logic [pbp_pkg::SIZE_W-1:0]   current_fill,
	input  logic [pbp_pkg::SIZE_W-1:0]   next_fill,
	input  logic [pbp_pkg::TOTAL_W-1:0]  received_count,
	input  logic [pbp_pkg::TOTAL_W-1:0]  dropped_count,
	output logic [OFFSET_BITS-1:0]       window_start_nx,
	output logic [pbp_pkg::SIZE_W-1:0]   current_fill_nx,
	output logic [pbp_pkg::SIZE_W-1:0]   next_fill_nx,
	output logic [pbp_pkg::TOTAL_W-1:0]  received_count_nx,
	output logic [pbp_pkg::TOTAL_W-1:0]  dropped_count_nx,
	output pbp_pkg::result_t             result
);
	import pbp_pkg::*;

	localparam int EW = 65;

	// saturating 32-bit add of a packet length
	function automatic logic [SIZE_W-1:0] sat_add(input logic [SIZE_W-1:0] a,
			input logic [BYTES_W-1:0] b);
		logic [SIZE_W:0] s;
		s = {1'b0, a} + {17'd0, b};
		return s[SIZE_W] ? {SIZE_W{1'b1}} : s[SIZE_W-1:0];
	endfunction

	logic [EW-1:0]        rel_e;
	logic [EW-1:0]        size_e;
	logic [EW-1:0]        size2_e;
	logic [EW-1:0]        ws_sum_e;
	logic [OFFSET_BITS-1:0] rel;
	logic                 late;
	logic                 in_cur;
	logic                 in_next;
	logic                 beyond;
	logic [SIZE_W-1:0]    cur_upd;
	logic [SIZE_W-1:0]    nxt_upd;
	logic                 closed;
	logic [SIZE_W-1:0]    missing;
	logic                 placed;

	// window compares on widened operands
	always_comb begin
		rel      = offset - window_start;
		rel_e    = {{(EW-OFFSET_BITS){1'b0}}, rel};
		size_e   = {{(EW-SIZE_W){1'b0}}, block_size};
		size2_e  = {size_e[EW-2:0], 1'b0};
		ws_sum_e = {{(EW-OFFSET_BITS){1'b0}}, window_start} + size_e;
		late     = (kind == KIND_DATA) && (offset < window_start);
		in_cur   = (kind == KIND_DATA) && !late && (rel_e < size_e);
		in_next  = (kind == KIND_DATA) && !late && !in_cur && (rel_e < size2_e);
		beyond   = (kind == KIND_DATA) && !late && !in_cur && !in_next;
		placed   = in_cur || in_next;
	end

	// fill update, close check and state for the next item
	always_comb begin
		cur_upd = in_cur ? sat_add(current_fill, bytes) : current_fill;
		nxt_upd = in_next ? sat_add(next_fill, bytes) : next_fill;
		closed  = beyond || (cur_upd >= block_size);
		missing = (closed && (block_size > cur_upd)) ? block_size - cur_upd : '0;

		received_count_nx = placed ? received_count + {48'd0, bytes} : received_count;
		dropped_count_nx  = dropped_count + {32'd0, missing};
		if (closed) begin
			window_start_nx = ws_sum_e[OFFSET_BITS-1:0];
			current_fill_nx = nxt_upd;
			next_fill_nx    = '0;
		end else begin
			window_start_nx = window_start;
			current_fill_nx = cur_upd;
			next_fill_nx    = nxt_upd;
		end
	end

	// result item
	always_comb begin
		result = '0;
		priority if (in_cur) begin
			result.destination   = DEST_CURRENT;
			result.write_address = rel[SIZE_W-1:0];
		end else if (in_next) begin
			result.destination   = DEST_NEXT;
			result.write_address = rel[SIZE_W-1:0] - block_size;
		end else if (late) begin
			result.destination   = DEST_LATE;
		end else if (beyond) begin
			result.destination   = DEST_BEYOND;
		end else begin
			result.destination   = DEST_IGNORED;
		end
		result.consumed       = !beyond;
		result.block_closed   = closed;
		result.bytes_missing  = missing;
		result.stop_request   = (kind == KIND_STOP);
		result.received_total = received_count_nx;
		result.dropped_total  = dropped_count_nx;
	end

endmodule

### design/packet_block_placement_unit.sv
// top level of the packet block placement unit
// depends on pbp_pkg, pbp_if.sv (pbp_pkt_if, pbp_res_if) and pbp_core
//
// Packets come in on pkt (valid/ready): kind, stream byte offset, payload length.
// Each packet yields exactly one result on res (valid/ready): destination block,
// address within it, whether the packet was consumed, block close with missing
// bytes, stop request and the running received and dropped byte totals.
// A packet beyond both windows comes back with consumed low; the source presents
// it again and it is then placed against the rotated windows.
// The user writes block_size through cfg_we/cfg_wdata only with no packet in flight;
// the block does not enforce this. Each packet is held in the input register, then
// its result in the result register. Throughput: one packet per cycle unless res
// stalls, set by the single placement stage that reads and updates the window state.
// Reset clears the window start, both fills and both totals and sets block_size
// to 1048576; no clearing pass is needed. When res stalls the result stays in its
// register, one more packet is held in the input register, and pkt.ready drops
// until the result is taken.
module packet_block_placement_unit #(
	parameter int OFFSET_BITS = pbp_pkg::OFFSET_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	pbp_pkt_if.sink                     pkt,
	pbp_res_if.source                   res,
	input  logic                        cfg_we,
	input  logic [pbp_pkg::SIZE_W-1:0]  cfg_wdata
);
	import pbp_pkg::*;

	// input stage
	logic                  valid_s1;
	logic [KIND_W-1:0]     kind_s1;
	logic [OFFSET_BITS-1:0] offset_s1;
	logic [BYTES_W-1:0]    bytes_s1;

	// window state and register
	logic [SIZE_W-1:0]     block_size_q;
	logic [OFFSET_BITS-1:0] window_start_q;
	logic [SIZE_W-1:0]     current_fill_q;
	logic [SIZE_W-1:0]     next_fill_q;
	logic [TOTAL_W-1:0]    received_q;
	logic [TOTAL_W-1:0]    dropped_q;

	logic [OFFSET_BITS-1:0] window_start_nx;
	logic [SIZE_W-1:0]     current_fill_nx;
	logic [SIZE_W-1:0]     next_fill_nx;
	logic [TOTAL_W-1:0]    received_nx;
	logic [TOTAL_W-1:0]    dropped_nx;
	result_t               result_nx;

	// result register
	logic                  res_valid_q;
	result_t               res_q;

	logic                  advance;
	logic                  pkt_take;
	logic [63:0]           offset_wide;

	assign advance     = valid_s1 && (!res_valid_q || res.ready);
	assign pkt.ready   = !valid_s1 || advance;
	assign pkt_take    = pkt.valid && pkt.ready;
	assign offset_wide = {{(64-OFFS_W){1'b0}}, pkt.packet_offset};

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pkt_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt_take) begin
			kind_s1   <= pkt.packet_kind;
			offset_s1 <= offset_wide[OFFSET_BITS-1:0];
			bytes_s1  <= pkt.packet_bytes;
		end
	end

	pbp_core #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_core (
		.kind              (kind_s1),
		.offset            (offset_s1),
		.bytes             (bytes_s1),
		.block_size        (block_size_q),
		.window_start      (window_start_q),
		.current_fill      (current_fill_q),
		.next_fill         (next_fill_q),
		.received_count    (received_q),
		.dropped_count     (dropped_q),
		.window_start_nx   (window_start_nx),
		.current_fill_nx   (current_fill_nx),
		.next_fill_nx      (next_fill_nx),
		.received_count_nx (received_nx),
		.dropped_count_nx  (dropped_nx),
		.result            (result_nx)
	);

	// block size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q <= BLOCK_SIZE_RESET;
		end else if (cfg_we) begin
			block_size_q <= cfg_wdata;
		end
	end

	// window state, updated as each item leaves the placement stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_start_q <= '0;
			current_fill_q <= '0;
			next_fill_q    <= '0;
			received_q     <= '0;
			dropped_q      <= '0;
		end else if (advance) begin
			window_start_q <= window_start_nx;
			current_fill_q <= current_fill_nx;
			next_fill_q    <= next_fill_nx;
			received_q     <= received_nx;
			dropped_q      <= dropped_nx;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= result_nx;
		end
	end

	assign res.valid          = res_valid_q;
	assign res.destination    = res_q.destination;
	assign res.write_address  = res_q.write_address;
	assign res.consumed       = res_q.consumed;
	assign res.block_closed   = res_q.block_closed;
	assign res.bytes_missing  = res_q.bytes_missing;
	assign res.stop_request   = res_q.stop_request;
	assign res.received_total = res_q.received_total;
	assign res.dropped_total  = res_q.dropped_total;

endmodule

### tb/packet_block_placement_unit_tb.sv
// testbench for packet_block_placement_unit: random and directed packets against a built-in
// placement predictor, results compared field by field in order of arrival
// depends on pbp_pkg, pbp_if.sv (pbp_pkt_if, pbp_res_if) and packet_block_placement_unit
module packet_block_placement_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pbp_pkg::*;

	// cycles with no item moving on either channel before the run is called hung;
	// the slowest item sees the longest random send gap and receive stall and the
	// pipeline latency, and a block size change adds a short drain pause
	localparam int HUSH_LIMIT = 500;

	// one packet as presented, with leave to present it again once if handed back
	typedef struct packed {
		kind_t               kind;
		logic [OFFS_W-1:0]   offs;
		logic [BYTES_W-1:0]  nbytes;
		logic                retry_ok;
	} pkt_item_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we = 1'b0;
	logic [SIZE_W-1:0] cfg_wdata = '0;

	pbp_pkt_if pkt_ch ();
	pbp_res_if res_ch ();

	packet_block_placement_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt       (pkt_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predicted placement state
	logic [OFFS_W-1:0]  win_start  = '0;
	logic [SIZE_W-1:0]  cur_fill   = '0;
	logic [SIZE_W-1:0]  nxt_fill   = '0;
	logic [SIZE_W-1:0]  blk_size   = BLOCK_SIZE_RESET;
	logic [TOTAL_W-1:0] rx_total   = '0;
	logic [TOTAL_W-1:0] drop_total = '0;

	pkt_item_t packets_todo[$];
	result_t   placements_due[$];
	pkt_item_t on_wire = '0;
	bit  src_busy, pkt_took, res_took, rush, calm;
	int  src_wait, snk_wait, mismatches, hush;

	// fill counters stick at all ones
	function automatic logic [SIZE_W-1:0] fill_add(input logic [SIZE_W-1:0] a,
			input logic [BYTES_W-1:0] b);
		logic [SIZE_W:0] s;
		s = {1'b0, a} + b;
		return s[SIZE_W] ? '1 : s[SIZE_W-1:0];
	endfunction

	// place one packet, update the window state and return the result it yields
	function automatic result_t place_packet(input pkt_item_t it);
		result_t r;
		logic [63:0] rel, bs;
		logic beyond;
		r = '0;
		r.destination = DEST_IGNORED;
		r.consumed = 1'b1;
		beyond = 1'b0;
		bs = {32'd0, blk_size};
		if (it.kind == KIND_DATA) begin
			if (it.offs < win_start) begin
				r.destination = DEST_LATE;
			end else begin
				rel = {16'd0, it.offs - win_start};
				if (rel < bs) begin
					r.destination = DEST_CURRENT;
					r.write_address = rel[SIZE_W-1:0];
					cur_fill = fill_add(cur_fill, it.nbytes);
					rx_total += it.nbytes;
				end else if (rel - bs < bs) begin
					r.destination = DEST_NEXT;
					r.write_address = rel[SIZE_W-1:0] - blk_size;
					nxt_fill = fill_add(nxt_fill, it.nbytes);
					rx_total += it.nbytes;
				end else begin
					r.destination = DEST_BEYOND;
					r.consumed = 1'b0;
					beyond = 1'b1;
				end
			end
		end else if (it.kind == KIND_STOP) begin
			r.stop_request = 1'b1;
		end
		// close on a packet beyond the windows or on a full current block
		if (beyond || cur_fill >= blk_size) begin
			r.block_closed = 1'b1;
			r.bytes_missing = (blk_size > cur_fill) ? blk_size - cur_fill : '0;
			drop_total += r.bytes_missing;
			win_start = win_start + blk_size;
			cur_fill = nxt_fill;
			nxt_fill = '0;
		end
		r.received_total = rx_total;
		r.dropped_total = drop_total;
		return r;
	endfunction

	function automatic int idle_draw();
		return (rush || calm) ? 0 : int'($urandom_range(0, 16));
	endfunction

	task automatic flag_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s expected %0h got %0h", $time, name, want, got);
		end
	endtask

	// packet side: predict each accepted item, hand back unconsumed ones once
	always @(posedge clk) begin : pkt_watch
		result_t r;
		pkt_item_t redo;
		pkt_took = arst_n && pkt_ch.valid && pkt_ch.ready;
		if (pkt_took) begin
			r = place_packet(on_wire);
			placements_due.push_back(r);
			if (!r.consumed && on_wire.retry_ok) begin
				redo = on_wire;
				redo.retry_ok = 1'b0;
				packets_todo.push_front(redo);
			end
		end
	end

	// packet driver with a random gap before each item
	always @(negedge clk) begin : pkt_drive
		logic [63:0] junk;
		junk = {$urandom, $urandom};
		if (pkt_took) begin
			src_busy = 1'b0;
			src_wait = idle_draw();
		end
		if (arst_n && !src_busy) begin
			if (src_wait > 0)
				src_wait--;
			else if (packets_todo.size() != 0) begin
				on_wire = packets_todo.pop_front();
				src_busy = 1'b1;
			end
		end
		pkt_ch.valid <= src_busy;
		if (src_busy) begin
			pkt_ch.packet_kind   <= on_wire.kind;
			pkt_ch.packet_offset <= on_wire.offs;
			pkt_ch.packet_bytes  <= on_wire.nbytes;
		end else begin
			pkt_ch.packet_kind   <= junk[KIND_W-1:0];
			pkt_ch.packet_offset <= junk[OFFS_W-1:0];
			pkt_ch.packet_bytes  <= junk[63:64-BYTES_W];
		end
	end

	// result side: compare with the oldest placement owed
	always @(posedge clk) begin : res_watch
		result_t want;
		res_took = arst_n && res_ch.valid && res_ch.ready;
		if (res_took) begin
			if (placements_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with no placement owed", $time);
			end else begin
				want = placements_due.pop_front();
				flag_field("destination", want.destination, res_ch.destination);
				flag_field("write_address", want.write_address, res_ch.write_address);
				flag_field("consumed", want.consumed, res_ch.consumed);
				flag_field("block_closed", want.block_closed, res_ch.block_closed);
				flag_field("bytes_missing", want.bytes_missing, res_ch.bytes_missing);
				flag_field("stop_request", want.stop_request, res_ch.stop_request);
				flag_field("received_total", want.received_total, res_ch.received_total);
				flag_field("dropped_total", want.dropped_total, res_ch.dropped_total);
			end
		end
	end

	// result receiver stalls for a random time after each item
	always @(negedge clk) begin
		if (res_took)
			snk_wait = idle_draw();
		else if (snk_wait > 0)
			snk_wait--;
		res_ch.ready <= arst_n && snk_wait == 0;
	end

	// watchdog on cycles with nothing moving
	always @(posedge clk) begin
		if (!arst_n || (pkt_ch.valid && pkt_ch.ready) || (res_ch.valid && res_ch.ready))
			hush = 0;
		else
			hush++;
		if (hush >= HUSH_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic send(input kind_t k, input logic [OFFS_W-1:0] o, input logic [BYTES_W-1:0] n,
			input logic again);
		pkt_item_t it;
		while (packets_todo.size() >= 2)
			@(posedge clk);
		it.kind = k;
		it.offs = o;
		it.nbytes = n;
		it.retry_ok = again;
		packets_todo.push_back(it);
	endtask

	task automatic drain();
		while (packets_todo.size() != 0 || src_busy || placements_due.size() != 0)
			@(posedge clk);
	endtask

	// block size changes only with nothing in flight
	task automatic write_block_size(input logic [SIZE_W-1:0] v);
		drain();
		repeat (3) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		blk_size = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly packets aimed at or around the windows, some noise
	task automatic send_random();
		logic [63:0] bs, rel, off;
		logic [BYTES_W-1:0] n;
		kind_t k;
		int pick;
		bs = {32'd0, blk_size};
		pick = $urandom_range(0, 99);
		k = KIND_DATA;
		case ($urandom_range(0, 7))
			0: n = '0;
			1: n = '1;
			2, 3, 4: n = BYTES_W'($urandom_range(0, 64));
			default: n = BYTES_W'($urandom_range(0, 65535));
		endcase
		rel = {$urandom, $urandom};
		if (bs != 0) begin
			case ($urandom_range(0, 5))
				0: rel = 0;
				1: rel = bs - 1;
				default: rel = rel % bs;
			endcase
		end
		if (pick < 55)
			off = win_start + rel;
		else if (pick < 70)
			off = win_start + bs + rel;
		else if (pick < 78)
			off = win_start + 2 * bs + (pick[0] ? 64'd0 : rel);
		else if (pick < 83 && win_start != 0)
			off = win_start - 1 - (rel % win_start);
		else begin
			off = {$urandom, $urandom};
			if (pick >= 87)
				k = (pick < 93) ? KIND_IGNORE : (pick < 97) ? KIND_STOP : KIND_SPARE;
		end
		send(k, off[OFFS_W-1:0], n, 1'b1);
	endtask

	initial begin
		logic [SIZE_W-1:0] sizes[7];
		arst_n = 1'b0;
		pkt_ch.valid = 1'b0;
		pkt_ch.packet_kind = '0;
		pkt_ch.packet_offset = '0;
		pkt_ch.packet_bytes = '0;
		res_ch.ready = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: window edges, every kind, late and beyond at the reset block size
		send(KIND_DATA, '0, '0, 1'b1);
		send(KIND_DATA, '0, '1, 1'b1);
		send(KIND_DATA, OFFS_W'(BLOCK_SIZE_RESET - 1), 16'd1, 1'b1);
		send(KIND_DATA, OFFS_W'(BLOCK_SIZE_RESET), 16'd100, 1'b1);
		send(KIND_DATA, OFFS_W'(2 * BLOCK_SIZE_RESET - 1), 16'd7, 1'b1);
		send(KIND_IGNORE, '1, '1, 1'b1);
		send(KIND_STOP, '0, '0, 1'b1);
		send(KIND_SPARE, OFFS_W'(BLOCK_SIZE_RESET), 16'd3, 1'b1);
		// beyond, then presented again into the rotated windows
		send(KIND_DATA, OFFS_W'(2 * BLOCK_SIZE_RESET), 16'd5, 1'b1);
		send(KIND_DATA, '0, 16'd9, 1'b1);
		// top of the offset range stays beyond after one rotation
		send(KIND_DATA, '1, '1, 1'b1);
		send(KIND_DATA, OFFS_W'(3 * BLOCK_SIZE_RESET), 16'd1, 1'b1);

		// random phases over block sizes, smallest and largest among them
		sizes = '{32'd1, 32'd16, 32'd1000, 32'd0, 32'd65535, 32'hFFFF_FFFF, 32'd300};
		foreach (sizes[i]) begin
			write_block_size(sizes[i]);
			repeat (55) begin
				if ($urandom_range(0, 19) == 0)
					calm = !calm;
				send_random();
			end
		end
		calm = 1'b0;

		write_block_size(32'd300);
		repeat (50) send_random();

		// let the pipe empty, then allow a spurious late result to show
		rush = 1'b1;
		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
